// ===== design/wtcs_pkg.sv =====
// Package for the textured wall column scaler: beat structs, state codes,
// register codes and fixed size limits. No dependencies.
`default_nettype none

package wtcs_pkg;

  localparam int unsigned MAX_TEX_SIZE    = 4096;
  localparam int unsigned MAX_SCREEN_ROWS = 4096;

  // Quotient of the texel row divide is always below MAX_TEX_SIZE.
  localparam int unsigned DIV_STEPS = 13;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    FACE_SOUTH = 2'd0,
    FACE_NORTH = 2'd1,
    FACE_EAST  = 2'd2,
    FACE_WEST  = 2'd3
  } face_t;

  typedef enum logic [1:0] {
    REG_SCREEN_HEIGHT   = 2'd0,
    REG_LINE_LENGTH     = 2'd1,
    REG_BYTES_PER_PIXEL = 2'd2
  } reg_idx_t;

  localparam logic KIND_START = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_MUL_K,
    ST_DIV,
    ST_MUL_T,
    ST_MUL_L,
    ST_MUL_C,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic               kind;
    logic [11:0]        column;
    logic signed [15:0] start_row;
    logic [23:0]        wall_height;
    logic [31:0]        hit_x;
    logic [31:0]        hit_y;
    logic [1:0]         face;
    logic [12:0]        tex_width;
    logic [12:0]        tex_height;
  } item_t;

  typedef struct packed {
    logic [27:0] dest_offset;
    logic [23:0] texel_index;
    logic [1:0]  texture_select;
    logic        visible;
    logic        last;
  } pixel_t;

endpackage

`default_nettype wire

// ===== design/wall_texture_column_scaler_core.sv =====
// Textured wall column scaler: address generator for one raycaster wall column.
// One shared multiplier and a restoring divider run under a small sequencer.
// Depends on wtcs_pkg.
//
//  channel   direction  handshake                 payload
//  item      in         item_valid / item_stall   item_t  (start or step)
//  pix       out        pix_valid / pix_stall     pixel_t (one per active step)
//  apb       in/out     psel penable pwrite pready  paddr, pwdata, prdata
//
// A start beat passes through ST_START; a step beat that yields a pixel passes through
// ST_MUL_K, ST_DIV, ST_MUL_T, ST_MUL_L, ST_MUL_C and ST_EMIT: the texel row divide makes
// a 13-bit quotient, one quotient bit per cycle, and the multiplier is shared by five products, one per cycle.
// A step while no column is active yields nothing.
// Reset (rst, synchronous) returns the sequencer to idle and the registers to
// 480 rows, 2560 bytes per row, 4 bytes per pixel.
// A stalled pixel holds in the output register; the next item is taken meanwhile.
`default_nettype none

module wall_texture_column_scaler_core
  import wtcs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  output logic             item_stall,
  input  wire item_t       item,
  output logic             pix_valid,
  input  wire logic        pix_stall,
  output pixel_t           pix,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned ROW_W = $clog2(MAX_SCREEN_ROWS);

  // configuration
  logic [12:0] screen_height;
  logic [15:0] line_length;
  logic [3:0]  image_bytes_per_pixel;
  logic        cfg_wr;
  logic [12:0] screen_rows;

  // column state
  state_t       state, state_next;
  logic         active;
  logic [16:0]  span_counter;
  logic [16:0]  span_end;
  logic signed [17:0] current_row;
  logic [11:0]  column_reg;
  logic [23:0]  height_reg;
  logic [11:0]  column_offset;
  logic [12:0]  tex_w;
  logic [12:0]  tex_h;
  logic [1:0]   face_reg;
  logic [15:0]  frac;

  // per pixel work registers
  logic [23:0]           rem;
  logic [12:0]           div_bits;
  logic [12:0]           quotient;
  logic [DIV_CNT_W-1:0]  div_cnt;
  logic                  vis;
  logic [23:0]           texel_acc;
  logic [27:0]           dest_acc;

  // shared multiplier
  logic [16:0] mul_a;
  logic [15:0] mul_b;
  logic [32:0] prod;

  logic        item_acc;
  logic        emit_ok;
  logic        last_px;
  logic [24:0] rem_shift;
  logic        div_ge;

  // start beat decode
  logic [12:0] tw_sat, th_sat;
  logic [15:0] frac_in;
  logic [20:0] screen_span;
  logic [23:0] over;
  logic [16:0] k0_in, kend_in;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  assign screen_rows = (screen_height > 13'(MAX_SCREEN_ROWS)) ?
                       13'(MAX_SCREEN_ROWS) : screen_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_height         <= 13'd480;
      line_length           <= 16'd2560;
      image_bytes_per_pixel <= 4'd4;
    end else if (cfg_wr) begin
      case (reg_idx_t'(paddr[3:2]))
        REG_SCREEN_HEIGHT:   screen_height         <= pwdata[12:0];
        REG_LINE_LENGTH:     line_length           <= pwdata[15:0];
        REG_BYTES_PER_PIXEL: image_bytes_per_pixel <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[3:2]))
      REG_SCREEN_HEIGHT:   prdata = {19'd0, screen_height};
      REG_LINE_LENGTH:     prdata = {16'd0, line_length};
      REG_BYTES_PER_PIXEL: prdata = {28'd0, image_bytes_per_pixel};
      default:             prdata = 32'd0;
    endcase
  end

  assign item_acc = item_valid & ~item_stall;
  assign emit_ok  = ~pix_valid | ~pix_stall;

  always_comb begin
    tw_sat = (item.tex_width > 13'(MAX_TEX_SIZE)) ? 13'(MAX_TEX_SIZE) : item.tex_width;
    th_sat = (item.tex_height > 13'(MAX_TEX_SIZE)) ? 13'(MAX_TEX_SIZE) : item.tex_height;
    case (face_t'(item.face))
      FACE_SOUTH: frac_in = 16'(17'h10000 - {1'b0, item.hit_y[15:0]});
      FACE_NORTH: frac_in = item.hit_y[15:0];
      FACE_EAST:  frac_in = item.hit_x[15:0];
      FACE_WEST:  frac_in = 16'(17'h10000 - {1'b0, item.hit_x[15:0]});
      default:    frac_in = item.hit_x[15:0];
    endcase
    // clip tall walls to a centred span
    screen_span = {screen_rows, 8'd0};
    over        = item.wall_height - 24'(screen_span);
    if ({3'd0, screen_span} < item.wall_height) begin
      k0_in   = {2'd0, over[23:9]};
      kend_in = 17'(screen_rows) + k0_in;
    end else begin
      k0_in   = 17'd0;
      kend_in = {1'b0, item.wall_height[23:8]};
    end
  end

  assign prod = {16'd0, mul_a} * {17'd0, mul_b};

  assign rem_shift = {rem, div_bits[12]};
  assign div_ge    = rem_shift >= {1'b0, height_reg};
  assign last_px   = (span_counter + 17'd1) >= span_end;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (item_acc) begin
          if (item.kind == KIND_START) begin
            state_next = ST_START;
          end else if (active) begin
            state_next = ST_MUL_K;
          end
        end
      end
      ST_START: state_next = ST_IDLE;
      ST_MUL_K: state_next = ST_DIV;
      ST_DIV: begin
        if (div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_next = ST_MUL_T;
        end
      end
      ST_MUL_T: state_next = ST_MUL_L;
      ST_MUL_L: state_next = ST_MUL_C;
      ST_MUL_C: state_next = ST_EMIT;
      ST_EMIT: begin
        if (emit_ok) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs: stall and multiplier operands
  always_comb begin
    item_stall = 1'b1;
    mul_a      = 17'd0;
    mul_b      = 16'd0;
    case (state)
      ST_IDLE: item_stall = 1'b0;
      ST_START: begin
        mul_a = {1'b0, frac};
        mul_b = {3'd0, tex_w};
      end
      ST_MUL_K: begin
        mul_a = span_counter;
        mul_b = {3'd0, tex_h};
      end
      ST_MUL_T: begin
        mul_a = {4'd0, quotient};
        mul_b = {3'd0, tex_w};
      end
      ST_MUL_L: begin
        mul_a = 17'(current_row[ROW_W-1:0]);
        mul_b = line_length;
      end
      ST_MUL_C: begin
        mul_a = {5'd0, column_reg};
        mul_b = {12'd0, image_bytes_per_pixel};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (state == ST_IDLE && item_acc && item.kind == KIND_START) begin
      active <= k0_in < kend_in;
    end else if (state == ST_EMIT && emit_ok && last_px) begin
      active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (item_acc && item.kind == KIND_START) begin
          span_counter <= k0_in;
          span_end     <= kend_in;
          current_row  <= 18'(item.start_row);
          column_reg   <= item.column;
          height_reg   <= item.wall_height;
          tex_w        <= tw_sat;
          tex_h        <= th_sat;
          face_reg     <= item.face;
          frac         <= frac_in;
        end
      end
      ST_START: column_offset <= prod[27:16];
      ST_MUL_K: begin
        // dividend is k*th*256; its top bits already sit below the divisor
        rem      <= prod[28:5];
        div_bits <= {prod[4:0], 8'd0};
        div_cnt  <= '0;
        vis      <= ~current_row[17] && (current_row[16:0] < {4'd0, screen_rows});
      end
      ST_DIV: begin
        rem      <= div_ge ? 24'(rem_shift - {1'b0, height_reg}) : rem_shift[23:0];
        div_bits <= {div_bits[11:0], 1'b0};
        quotient <= {quotient[11:0], div_ge};
        div_cnt  <= div_cnt + DIV_CNT_W'(1);
      end
      ST_MUL_T: texel_acc <= prod[23:0] + {12'd0, column_offset};
      ST_MUL_L: dest_acc  <= prod[27:0];
      ST_MUL_C: dest_acc  <= vis ? dest_acc + prod[27:0] : 28'd0;
      ST_EMIT: begin
        if (emit_ok) begin
          span_counter <= span_counter + 17'd1;
          current_row  <= current_row + 18'sd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (state == ST_EMIT && emit_ok) begin
      pix_valid <= 1'b1;
    end else if (!pix_stall) begin
      pix_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && emit_ok) begin
      pix.dest_offset    <= dest_acc;
      pix.texel_index    <= texel_acc;
      pix.texture_select <= face_reg;
      pix.visible        <= vis;
      pix.last           <= last_px;
    end
  end

endmodule

`default_nettype wire

// ===== design/wtcs_checker.sv =====
// Port-level checks for the wall column scaler, bound to the top level.
// Depends on wtcs_pkg.
`default_nettype none

module wtcs_checker
  import wtcs_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        item_valid,
  input wire logic        item_stall,
  input wire item_t       item,
  input wire logic        pix_valid,
  input wire logic        pix_stall,
  input wire pixel_t      pix,
  input wire logic [3:0]  paddr,
  input wire logic [31:0] prdata
);

  // hold a stalled pixel beat
  a_pix_hold: assert property (@(posedge clk) disable iff (rst)
    pix_valid && pix_stall |=> pix_valid && $stable(pix))
    else $error("stalled pixel beat changed");

  // a start beat always occupies the sequencer in ST_START, holding off the next item
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && item.kind == KIND_START |=> item_stall)
    else $error("start beat did not hold off the next item");

  // hidden rows carry no frame buffer offset
  a_hidden_zero: assert property (@(posedge clk) disable iff (rst)
    pix_valid && !pix.visible |-> pix.dest_offset == 28'd0)
    else $error("hidden pixel with nonzero offset");

  // a new pixel appears just as the sequencer goes idle
  a_emit_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(pix_valid) |-> !item_stall)
    else $error("pixel emitted while sequencer busy");

  a_reset_rows: assert property (@(posedge clk) disable iff (rst)
    $past(rst) && paddr == 4'h0 |-> prdata == 32'd480)
    else $error("screen height not at reset value");

endmodule

bind wall_texture_column_scaler_core wtcs_checker u_wtcs_checker (.*);

`default_nettype wire
